@@ rtl/core/sbmq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the shared-buffer multi-queue.
// No dependencies; every other file of the block refers to this package.
package sbmq_pkg;

    localparam int SLOTS    = 64;
    localparam int QUEUES   = 4;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W    = $clog2(SLOTS + 1);
    localparam int Q_W      = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QID_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic [PTR_W-1:0] ptr_t;

    // A pointer equal to SLOTS marks the end of a chain.
    localparam ptr_t NULL_PTR = ptr_t'(SLOTS);

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } sbmq_status_t;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } sbmq_cmd_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } sbmq_state_t;

    // Strobes and operands from the top-level sequencer to the pointer logic.
    typedef struct packed {
        logic                     accept;
        logic                     finish;
        sbmq_cmd_t                cmd;
        logic [QID_W-1:0]         qid;
        logic signed [DATA_W-1:0] value;
    } sbmq_op_t;

    typedef struct packed {
        sbmq_status_t             status;
        logic signed [DATA_W-1:0] data;
    } sbmq_result_t;

    typedef struct packed {
        logic              rd_en;
        ptr_t              rd_addr;
        logic              link_we;
        ptr_t              link_waddr;
        ptr_t              link_wdata;
        logic              data_we;
        ptr_t              data_waddr;
        logic [DATA_W-1:0] data_wdata;
    } sbmq_mem_req_t;

    typedef struct packed {
        ptr_t              link_rdata;
        logic [DATA_W-1:0] data_rdata;
    } sbmq_mem_rsp_t;

    function automatic logic is_slot(input ptr_t p);
        return p < ptr_t'(SLOTS);
    endfunction

    // Fold a queue id into range by repeated subtraction (id is only a few bits).
    function automatic logic [Q_W-1:0] queue_sel(input logic [QID_W-1:0] id);
        logic [QID_W:0] r;
        r = {1'b0, id};
        for (int i = 0; i < (1 << QID_W); i++) begin
            if (int'(r) >= QUEUES) begin
                r = r - (QID_W + 1)'(QUEUES);
            end
        end
        return Q_W'(r);
    endfunction

endpackage

@@ rtl/core/sbmq_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the shared-buffer multi-queue: valid/ready plus one command item.
// Depends on sbmq_pkg for field widths.
interface sbmq_req_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [sbmq_pkg::QID_W-1:0]       queue_id;
    logic signed [sbmq_pkg::DATA_W-1:0] value;

    modport source (output valid, output cmd, output queue_id, output value, input ready);
    modport sink   (input valid, input cmd, input queue_id, input value, output ready);
endinterface

@@ rtl/core/sbmq_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel of the shared-buffer multi-queue: valid/ready plus one result item.
// Depends on sbmq_pkg for field widths.
interface sbmq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [sbmq_pkg::STATUS_W-1:0]        status;
    logic signed [sbmq_pkg::DATA_W-1:0]   data;

    modport source (output valid, output status, output data, input ready);
    modport sink   (input valid, input status, input data, output ready);
endinterface

@@ rtl/core/sbmq_slot_store.sv @@
`timescale 1ns / 1ps
// Slot store: link memory and data memory, one write and one registered read each.
// Depends on sbmq_pkg for the request and response structs.
module sbmq_slot_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sbmq_pkg::sbmq_mem_req_t mem_req,
    output sbmq_pkg::sbmq_mem_rsp_t mem_rsp
);

    logic [sbmq_pkg::PTR_W-1:0]  link_mem [sbmq_pkg::SLOTS];
    logic [sbmq_pkg::DATA_W-1:0] data_mem [sbmq_pkg::SLOTS];

    sbmq_pkg::ptr_t              fill_reg;
    sbmq_pkg::ptr_t              fill_next;
    sbmq_pkg::ptr_t              link_raw_reg;
    sbmq_pkg::ptr_t              succ_reg;
    logic                        fresh_reg;
    logic [sbmq_pkg::DATA_W-1:0] data_rd_reg;

    // Slots are first written in ascending order, so every slot at or above
    // the fill count still holds its reset link (its own index plus one).
    always_comb
    begin
        fill_next = fill_reg;
        if (mem_req.link_we && (mem_req.link_waddr == fill_reg)) begin
            fill_next = fill_reg + sbmq_pkg::ptr_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.link_we) begin
            link_mem[mem_req.link_waddr[sbmq_pkg::SLOT_W-1:0]] <= mem_req.link_wdata;
        end
        if (mem_req.data_we) begin
            data_mem[mem_req.data_waddr[sbmq_pkg::SLOT_W-1:0]] <= mem_req.data_wdata;
        end
        if (mem_req.rd_en) begin
            link_raw_reg <= link_mem[mem_req.rd_addr[sbmq_pkg::SLOT_W-1:0]];
            data_rd_reg  <= data_mem[mem_req.rd_addr[sbmq_pkg::SLOT_W-1:0]];
            fresh_reg    <= (mem_req.rd_addr >= fill_reg);
            succ_reg     <= mem_req.rd_addr + sbmq_pkg::ptr_t'(1);
        end
    end

    assign mem_rsp.link_rdata = fresh_reg ? succ_reg : link_raw_reg;
    assign mem_rsp.data_rdata = data_rd_reg;

endmodule

@@ rtl/core/sbmq_ptr_ctrl.sv @@
`timescale 1ns / 1ps
// Pointer bookkeeping: queue heads and tails, free-list head, and the slot store accesses.
// Depends on sbmq_pkg; drives sbmq_slot_store through the memory request struct.
module sbmq_ptr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sbmq_pkg::sbmq_op_t      op,
    output sbmq_pkg::sbmq_result_t  result,
    output sbmq_pkg::sbmq_mem_req_t mem_req,
    input  sbmq_pkg::sbmq_mem_rsp_t mem_rsp
);

    sbmq_pkg::ptr_t         head_reg [sbmq_pkg::QUEUES];
    sbmq_pkg::ptr_t         head_next [sbmq_pkg::QUEUES];
    sbmq_pkg::ptr_t         tail_reg [sbmq_pkg::QUEUES];
    sbmq_pkg::ptr_t         tail_next [sbmq_pkg::QUEUES];
    sbmq_pkg::ptr_t         free_reg;
    sbmq_pkg::ptr_t         free_next;
    sbmq_pkg::sbmq_cmd_t    op_cmd_reg;
    sbmq_pkg::sbmq_cmd_t    op_cmd_next;
    logic [sbmq_pkg::Q_W-1:0] op_q_reg;
    logic [sbmq_pkg::Q_W-1:0] op_q_next;
    sbmq_pkg::ptr_t         op_slot_reg;
    sbmq_pkg::ptr_t         op_slot_next;
    sbmq_pkg::sbmq_status_t op_status_reg;
    sbmq_pkg::sbmq_status_t op_status_next;

    logic [sbmq_pkg::Q_W-1:0] q;
    sbmq_pkg::ptr_t           hd;
    sbmq_pkg::ptr_t           tl;

    assign q  = sbmq_pkg::queue_sel(op.qid);
    assign hd = head_reg[q];
    assign tl = tail_reg[q];

    always_comb
    begin
        mem_req        = '0;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_next      = free_reg;
        op_cmd_next    = op_cmd_reg;
        op_q_next      = op_q_reg;
        op_slot_next   = op_slot_reg;
        op_status_next = op_status_reg;

        if (op.accept) begin
            op_cmd_next = op.cmd;
            op_q_next   = q;
            if (op.cmd == sbmq_pkg::CMD_ENQ) begin
                if (sbmq_pkg::is_slot(free_reg)) begin
                    // Fetch the free slot's successor, store the value, append.
                    mem_req.rd_en      = 1'b1;
                    mem_req.rd_addr    = free_reg;
                    mem_req.data_we    = 1'b1;
                    mem_req.data_waddr = free_reg;
                    mem_req.data_wdata = op.value;
                    if (sbmq_pkg::is_slot(hd)) begin
                        mem_req.link_we    = 1'b1;
                        mem_req.link_waddr = tl;
                        mem_req.link_wdata = free_reg;
                    end else begin
                        head_next[q] = free_reg;
                    end
                    tail_next[q]   = free_reg;
                    op_slot_next   = free_reg;
                    op_status_next = sbmq_pkg::STAT_OK;
                end else begin
                    op_status_next = sbmq_pkg::STAT_OVERFLOW;
                end
            end else begin
                if (sbmq_pkg::is_slot(hd)) begin
                    mem_req.rd_en  = 1'b1;
                    mem_req.rd_addr = hd;
                    op_slot_next   = hd;
                    op_status_next = sbmq_pkg::STAT_OK;
                end else begin
                    op_status_next = sbmq_pkg::STAT_UNDERFLOW;
                end
            end
        end

        if (op.finish && (op_status_reg == sbmq_pkg::STAT_OK)) begin
            mem_req.link_we    = 1'b1;
            mem_req.link_waddr = op_slot_reg;
            if (op_cmd_reg == sbmq_pkg::CMD_ENQ) begin
                // Terminate the new tail and advance the free list.
                mem_req.link_wdata = sbmq_pkg::NULL_PTR;
                free_next          = mem_rsp.link_rdata;
            end else begin
                // Advance the queue head and push the slot onto the free list.
                mem_req.link_wdata  = free_reg;
                head_next[op_q_reg] = mem_rsp.link_rdata;
                free_next           = op_slot_reg;
            end
        end
    end

    always_comb
    begin
        result.status = op_status_reg;
        result.data   = '0;
        if ((op_cmd_reg == sbmq_pkg::CMD_DEQ) && (op_status_reg == sbmq_pkg::STAT_OK)) begin
            result.data = mem_rsp.data_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < sbmq_pkg::QUEUES; i++) begin
                head_reg[i] <= sbmq_pkg::NULL_PTR;
                tail_reg[i] <= sbmq_pkg::NULL_PTR;
            end
            free_reg      <= '0;
            op_cmd_reg    <= sbmq_pkg::CMD_ENQ;
            op_q_reg      <= '0;
            op_slot_reg   <= '0;
            op_status_reg <= sbmq_pkg::STAT_OK;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            op_cmd_reg    <= op_cmd_next;
            op_q_reg      <= op_q_next;
            op_slot_reg   <= op_slot_next;
            op_status_reg <= op_status_next;
        end
    end

endmodule

@@ rtl/core/shared_buffer_multi_queue.sv @@
`timescale 1ns / 1ps
// Top level of the shared-buffer multi-queue: sequencer, result register, submodules.
// Depends on sbmq_pkg, sbmq_req_if, sbmq_rsp_if, sbmq_slot_store and sbmq_ptr_ctrl.
//
//  channel | direction | fields                                  | item accepted when
//  req     | in        | cmd[0], queue_id[1:0], value[31:0] s    | req.valid && req.ready
//  rsp     | out       | status[1:0], data[31:0] s               | rsp.valid && rsp.ready
//
// For each item, the accept cycle issues the slot-store read, and the finishing cycle
// uses the registered read data to finish the pointer update and load the result
// register.
// An item is accepted while the previous result still waits; the finishing cycle
// holds until the result register is free, and the read data holds with it.
// Reset empties every queue and puts all slots on the free list at once: the link
// memory needs no clearing pass, a fill count stands in for its reset contents.
module shared_buffer_multi_queue (
    input logic        clk,
    input logic        rst_n,
    sbmq_req_if.sink   req,
    sbmq_rsp_if.source rsp
);

    sbmq_pkg::sbmq_state_t   state_reg;
    sbmq_pkg::sbmq_state_t   state_next;
    logic                    accept;
    logic                    finish;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic [sbmq_pkg::STATUS_W-1:0]    rsp_status_reg;
    logic signed [sbmq_pkg::DATA_W-1:0] rsp_data_reg;

    sbmq_pkg::sbmq_op_t      op;
    sbmq_pkg::sbmq_result_t  result;
    sbmq_pkg::sbmq_mem_req_t mem_req;
    sbmq_pkg::sbmq_mem_rsp_t mem_rsp;

    // Next state: one item in flight at a time.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbmq_pkg::FSM_IDLE:
            begin
                if (accept) begin
                    state_next = sbmq_pkg::FSM_EXEC;
                end
            end
            sbmq_pkg::FSM_EXEC:
            begin
                if (finish) begin
                    state_next = sbmq_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = sbmq_pkg::FSM_IDLE;
            end
        endcase
    end

    // Outputs: take an item when idle, finish once the result register is free.
    always_comb
    begin
        req.ready = 1'b0;
        finish    = 1'b0;
        unique case (state_reg)
            sbmq_pkg::FSM_IDLE:
            begin
                req.ready = 1'b1;
            end
            sbmq_pkg::FSM_EXEC:
            begin
                finish = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    assign op.accept = accept;
    assign op.finish = finish;
    assign op.cmd    = sbmq_pkg::sbmq_cmd_t'(req.cmd);
    assign op.qid    = req.queue_id;
    assign op.value  = req.value;

    sbmq_ptr_ctrl u_ptr_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .result  (result),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    sbmq_slot_store u_slot_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    // Result register: load on finish, drop once taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (finish) begin
            rsp_valid_next = 1'b1;
        end else if (rsp.ready) begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= sbmq_pkg::FSM_IDLE;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish) begin
            rsp_status_reg <= result.status;
            rsp_data_reg   <= result.data;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.data   = rsp_data_reg;

endmodule
